### rtl/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and codes for the bitmap frame allocator: command and result
// transactions, action codes and the word unit's control and status groups.
// ----------------------------------------------------------------------------
package bfa_pkg;

    localparam logic [2:0] ACT_ALLOC      = 3'd0;
    localparam logic [2:0] ACT_FREE       = 3'd1;
    localparam logic [2:0] ACT_USED       = 3'd2;
    localparam logic [2:0] ACT_RANGE_FREE = 3'd3;
    localparam logic [2:0] ACT_RANGE_USED = 3'd4;

    localparam logic [31:0] ALL_USED = 32'hFFFF_FFFF;
    localparam int          WORD_BITS = 32;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] start_addr;
        logic [31:0] end_addr;
    } bfa_cmd_t;

    typedef struct packed {
        logic [31:0] frame_addr;
        logic        out_of_memory;
    } bfa_result_t;

    typedef enum logic [1:0] {
        MODE_ALLOC = 2'd0,
        MODE_SET   = 2'd1,
        MODE_CLEAR = 2'd2
    } bfa_mode_t;

    typedef struct packed {
        bfa_mode_t  mode;
        logic [4:0] lo_off;
        logic [4:0] hi_off;
        logic       use_lo;
        logic       use_hi;
    } bfa_word_op_t;

    typedef struct packed {
        logic [31:0] new_word;
        logic        found;
        logic [4:0]  bit_idx;
    } bfa_word_res_t;

endpackage

### rtl/bfa_store.sv
// ----------------------------------------------------------------------------
// bfa_store
// Usage bitmap memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bfa_store
    import bfa_pkg::*;
#(
    parameter int WORD_COUNT = 1024,
    parameter int ADDR_W     = 10
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [31:0]       wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [31:0]       rd_data
);

    logic [31:0] mem [WORD_COUNT];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/bfa_word_unit.sv
// ----------------------------------------------------------------------------
// bfa_word_unit
// Shared word unit: finds the lowest free bit of a bitmap word and builds
// the updated word for an allocation or for a masked set/clear of a range.
// ----------------------------------------------------------------------------
module bfa_word_unit
    import bfa_pkg::*;
(
    input  logic [31:0]   word,
    input  bfa_word_op_t  op,
    output bfa_word_res_t res
);

    logic [31:0] free_bits;
    logic [15:0] sel16;
    logic [7:0]  sel8;
    logic [3:0]  sel4;
    logic [1:0]  sel2;
    logic [4:0]  idx;
    logic [31:0] lo_mask;
    logic [31:0] hi_mask;
    logic [31:0] mask;

    // Binary search for the lowest zero bit, five halving steps.
    always_comb
    begin
        free_bits = ~word;
        idx[4]    = ~|free_bits[15:0];
        sel16     = idx[4] ? free_bits[31:16] : free_bits[15:0];
        idx[3]    = ~|sel16[7:0];
        sel8      = idx[3] ? sel16[15:8] : sel16[7:0];
        idx[2]    = ~|sel8[3:0];
        sel4      = idx[2] ? sel8[7:4] : sel8[3:0];
        idx[1]    = ~|sel4[1:0];
        sel2      = idx[1] ? sel4[3:2] : sel4[1:0];
        idx[0]    = ~sel2[0];
    end

    always_comb
    begin
        lo_mask = op.use_lo ? (ALL_USED << op.lo_off) : ALL_USED;
        hi_mask = op.use_hi ? (ALL_USED >> (5'd31 - op.hi_off)) : ALL_USED;
        res.found   = |free_bits;
        res.bit_idx = idx;
        case (op.mode)
            MODE_ALLOC: mask = 32'd1 << idx;
            default:    mask = lo_mask & hi_mask;
        endcase
        case (op.mode)
            MODE_CLEAR: res.new_word = word & ~mask;
            default:    res.new_word = word | mask;
        endcase
    end

endmodule

### rtl/bitmap_frame_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// First-fit physical frame allocator over a one-bit-per-frame usage bitmap.
// ----------------------------------------------------------------------------
// Usage: after reset the block sweeps the bitmap, writing every word as used,
// one word per cycle across all ceil(NUM_FRAMES/32) words (1024 words at the
// default size); busy stays high during that sweep. A transaction is taken
// when start is high and busy is low, and busy then stays high until its one
// result has been strobed on done. The result stays on the result port
// until the next transaction is issued; the receiver cannot stall it, so
// capture it on done. Each transaction passes the setup and issue states,
// then takes one cycle per bitmap word touched: an allocation walks words
// from word 0 up to the word holding the first free frame (or up to the
// search limit, reporting out of memory), and a single-frame or range mark
// walks the words the range covers, one read-modify-write per cycle through
// the shared word unit and the bitmap memory's read and write ports. Unused
// action codes and empty ranges finish after setup. Busy drops in the same
// cycle done is strobed. The frame_count register may be written any time
// (cfg_ready is always high) but takes effect on the next allocation.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator
    import bfa_pkg::*;
#(
    parameter int NUM_FRAMES = 32768,
    parameter int PAGE_SHIFT = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  bfa_cmd_t    cmd,
    output logic        done,
    output bfa_result_t result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    // Sizes derived from the store
    localparam int WORD_COUNT = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int CNT_W      = $clog2(WORD_COUNT + 1);
    // Frame number width: big enough for an aligned-up end address, for
    // NUM_FRAMES itself and for a full word index plus bit offset.
    localparam int FW_A  = 33 - PAGE_SHIFT;
    localparam int FW_B  = $clog2(NUM_FRAMES + 1);
    localparam int FW_C  = ADDR_W + 5;
    localparam int FW_AB = (FW_A > FW_B) ? FW_A : FW_B;
    localparam int FW    = (FW_AB > FW_C) ? FW_AB : FW_C;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_SETUP = 6'b000100,
        ST_ISSUE = 6'b001000,
        ST_SCAN  = 6'b010000,
        ST_MARK  = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    bfa_cmd_t          cmd_reg, cmd_next;
    logic [FW-1:0]     first_reg, first_next;
    logic [FW-1:0]     last_reg, last_next;
    logic [CNT_W-1:0]  lim_reg, lim_next;
    logic [CNT_W-1:0]  cur_reg, cur_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [15:0]       frame_count_reg, frame_count_next;
    logic              done_reg, done_next;
    logic [31:0]       addr_reg, addr_next;
    logic              oom_reg, oom_next;

    // Store ports
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [31:0]       wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [31:0]       rd_data;

    // Shared unit
    bfa_word_op_t      op;
    bfa_word_res_t     wres;

    // Range setup arithmetic
    logic [32:0]       end_up;
    logic [FW-1:0]     first_raw;
    logic [FW-1:0]     last_raw;
    logic [FW-1:0]     last_pick;
    logic [FW-1:0]     last_m1;
    logic [ADDR_W-1:0] first_word;
    logic [ADDR_W-1:0] last_word;
    logic [ADDR_W-1:0] cur_addr;
    logic [16:0]       lim_full;
    logic [CNT_W-1:0]  cur_inc;
    logic              is_range;
    logic              set_used;
    logic [ADDR_W+PAGE_SHIFT+4:0] alloc_full;

    bfa_store #(
        .WORD_COUNT (WORD_COUNT),
        .ADDR_W     (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bfa_word_unit u_word_unit (
        .word (rd_data),
        .op   (op),
        .res  (wres)
    );

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result.frame_addr    = addr_reg;
    assign result.out_of_memory = oom_reg;

    // Frame bounds of the latched transaction: start aligned down, end
    // aligned up, single-frame actions cover exactly one frame.
    always_comb
    begin
        is_range  = (cmd_reg.action == ACT_RANGE_FREE) ||
                    (cmd_reg.action == ACT_RANGE_USED);
        set_used  = (cmd_reg.action == ACT_USED) ||
                    (cmd_reg.action == ACT_RANGE_USED);
        end_up    = {1'b0, cmd_reg.end_addr} + 33'((64'd1 << PAGE_SHIFT) - 64'd1);
        first_raw = FW'(cmd_reg.start_addr >> PAGE_SHIFT);
        last_raw  = FW'(end_up >> PAGE_SHIFT);
        last_pick = is_range ? last_raw : (first_raw + FW'(1));
        // Search limit: whole words below ceil(frame_count/8)/4, capped
        lim_full  = ({1'b0, frame_count_reg} + 17'd7) >> 5;
    end

    // Word walk bookkeeping
    always_comb
    begin
        last_m1    = last_reg - FW'(1);
        first_word = first_reg[ADDR_W+4:5];
        last_word  = last_m1[ADDR_W+4:5];
        cur_addr   = cur_reg[ADDR_W-1:0];
        cur_inc    = cur_reg + CNT_W'(1);
        alloc_full = {cur_addr, wres.bit_idx, {PAGE_SHIFT{1'b0}}};
    end

    // Shared unit control
    always_comb
    begin
        op.lo_off = first_reg[4:0];
        op.hi_off = last_m1[4:0];
        op.use_lo = (cur_addr == first_word);
        op.use_hi = (cur_addr == last_word);
        if (state_reg == ST_SCAN)
        begin
            op.mode = MODE_ALLOC;
        end
        else if (set_used)
        begin
            op.mode = MODE_SET;
        end
        else
        begin
            op.mode = MODE_CLEAR;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        first_next       = first_reg;
        last_next        = last_reg;
        lim_next         = lim_reg;
        cur_next         = cur_reg;
        clr_next         = clr_reg;
        frame_count_next = frame_count_reg;
        done_next        = 1'b0;
        addr_next        = addr_reg;
        oom_next         = oom_reg;
        wr_en            = 1'b0;
        wr_addr          = cur_addr;
        wr_data          = wres.new_word;
        rd_en            = 1'b0;
        rd_addr          = cur_inc[ADDR_W-1:0];

        if (cfg_valid && cfg_ready)
        begin
            frame_count_next = cfg_data;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Mark every word used, one per cycle
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = ALL_USED;
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(WORD_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                first_next = first_raw;
                last_next  = (last_pick > FW'(NUM_FRAMES)) ? FW'(NUM_FRAMES) : last_pick;
                lim_next   = (lim_full > 17'(WORD_COUNT)) ? CNT_W'(WORD_COUNT)
                                                          : CNT_W'(lim_full);
                state_next = ST_ISSUE;
            end
            ST_ISSUE:
            begin
                addr_next = 32'd0;
                oom_next  = 1'b0;
                case (cmd_reg.action) inside
                    ACT_ALLOC:
                    begin
                        if (lim_reg == '0)
                        begin
                            oom_next   = 1'b1;
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            cur_next   = '0;
                            state_next = ST_SCAN;
                        end
                    end
                    ACT_FREE, ACT_USED, ACT_RANGE_FREE, ACT_RANGE_USED:
                    begin
                        if (last_reg <= first_reg)
                        begin
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = first_word;
                            cur_next   = CNT_W'(first_word);
                            state_next = ST_MARK;
                        end
                    end
                    default:
                    begin
                        // Unused action: no change, zero result
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_SCAN:
            begin
                if (wres.found)
                begin
                    // Claim the lowest free bit of this word
                    wr_en      = 1'b1;
                    addr_next  = 32'(alloc_full);
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (cur_inc == lim_reg)
                begin
                    oom_next   = 1'b1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    // Advance: fetch the next word while checking this one
                    rd_en    = 1'b1;
                    cur_next = cur_inc;
                end
            end
            ST_MARK:
            begin
                wr_en = 1'b1;
                if (cur_addr == last_word)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    cur_next = cur_inc;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_reg         <= '0;
            frame_count_reg <= 16'd32768;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_reg         <= clr_next;
            frame_count_reg <= frame_count_next;
            done_reg        <= done_next;
        end
    end

    // Payload and walk registers
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        first_reg <= first_next;
        last_reg  <= last_next;
        lim_reg   <= lim_next;
        cur_reg   <= cur_next;
        addr_reg  <= addr_next;
        oom_reg   <= oom_next;
    end

endmodule
